>>> hw/rtl/prap_pkg.sv
// prap_pkg: shared types, fixed-point widths and constants of the point rotation unit.
// Contains the arctangent table of the CORDIC micro-rotations.
// No dependencies.
`default_nettype none

package prap_pkg;

  // Q16.16 coordinate and derived working widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned OFS_W      = COORD_W + 1;   // point - pivot, exact
  localparam int unsigned GUARD_BITS = 8;             // extra fraction bits inside CORDIC
  localparam int unsigned WORK_W     = 44;            // covers gain growth with margin
  localparam int unsigned CONST_W    = 30;            // gain and angle scale constants
  localparam int unsigned GAIN_FRAC  = 30;            // gain is Q30
  localparam int unsigned SCALE_SH   = GAIN_FRAC - GUARD_BITS;
  localparam int unsigned PROD_W     = OFS_W + CONST_W + 1;
  localparam int unsigned TURN_W     = 32;            // binary angle, 2^32 = one turn
  localparam int unsigned ANG_FRAC   = 16;            // fraction bits dropped from angle product
  localparam int unsigned APROD_W    = TURN_W + ANG_FRAC;
  localparam int unsigned ANG_W      = TURN_W + 2;    // residual angle, with growth
  localparam int unsigned ATAN_W     = 30;

  localparam logic [CONST_W-1:0] GAIN_Q30    = 30'd652032874;
  localparam logic [CONST_W-1:0] RAD_TO_TURN = 30'd683565276;
  localparam logic [CONST_W-1:0] DEG_TO_TURN = 30'd11930465;

  localparam logic signed [ANG_W-1:0] ANG_QUARTER     = ANG_W'(64'd1 << (TURN_W - 2));
  localparam logic signed [ANG_W-1:0] ANG_NEG_QUARTER = -ANG_QUARTER;
  localparam logic signed [ANG_W-1:0] ANG_HALF        = ANG_W'(64'd1 << (TURN_W - 1));

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] turn_angle;
    logic                      angle_in_degrees;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic                      overflow;
  } out_beat_t;

  // Working vector between CORDIC stages
  typedef struct packed {
    logic signed [WORK_W-1:0]  x;
    logic signed [WORK_W-1:0]  y;
    logic signed [ANG_W-1:0]   z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
  } rot_beat_t;

  // round(atan(2^-i) * 2^32 / (2 pi))
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000029;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000003;
      5'd29: r = 30'h00000001;
      5'd30: r = 30'h00000001;
      5'd31: r = 30'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/prap_stream_if.sv
// prap_stream_if: valid/ready stream channel, payload type set per instance.
// Instantiate with prap_pkg::in_beat_t or prap_pkg::out_beat_t.
`default_nettype none

interface prap_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prap_prep.sv
// prap_prep: three-stage front end: offset, gain and angle multiplies, quadrant fold.
// Depends on prap_pkg.
`default_nettype none

module prap_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  prap_pkg::in_beat_t   beat_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output prap_pkg::rot_beat_t  beat_o
);
  import prap_pkg::*;

  localparam logic signed [PROD_W-1:0] XY_RND  = PROD_W'(64'd1 << (SCALE_SH - 1));
  localparam logic [APROD_W-1:0]       ANG_RND = APROD_W'(64'd1 << (ANG_FRAC - 1));

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: exact offset
  logic signed [OFS_W-1:0]   ox_q, oy_q;
  logic signed [COORD_W-1:0] ang1_q, pvx1_q, pvy1_q;
  logic                      deg1_q;
  logic signed [OFS_W-1:0]   ox_d, oy_d;

  assign ox_d = OFS_W'(beat_i.point_x) - OFS_W'(beat_i.pivot_x);
  assign oy_d = OFS_W'(beat_i.point_y) - OFS_W'(beat_i.pivot_y);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      ang1_q <= beat_i.turn_angle;
      deg1_q <= beat_i.angle_in_degrees;
      pvx1_q <= beat_i.pivot_x;
      pvy1_q <= beat_i.pivot_y;
    end
  end

  // stage 2: gain pre-scale and angle-to-turn multiplies
  logic signed [PROD_W-1:0]        mx_d, my_d, mx_q, my_q;
  logic signed [COORD_W+CONST_W:0] ap_d;
  logic [CONST_W-1:0]              scale;
  logic [APROD_W-1:0]              ap_q;
  logic signed [COORD_W-1:0]       pvx2_q, pvy2_q;

  assign scale = deg1_q ? DEG_TO_TURN : RAD_TO_TURN;
  assign mx_d  = ox_q * $signed({1'b0, GAIN_Q30});
  assign my_d  = oy_q * $signed({1'b0, GAIN_Q30});
  assign ap_d  = ang1_q * $signed({1'b0, scale});

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      mx_q   <= mx_d;
      my_q   <= my_d;
      ap_q   <= ap_d[APROD_W-1:0];   // turn wraps modulo 2^32
      pvx2_q <= pvx1_q;
      pvy2_q <= pvy1_q;
    end
  end

  // stage 3: round to working format, binary angle, fold into a quarter turn
  logic signed [PROD_W-1:0] xr, yr;
  logic signed [WORK_W-1:0] x0, y0;
  logic [APROD_W-1:0]       ar;
  logic [TURN_W-1:0]        turn;
  logic signed [ANG_W-1:0]  zw;
  rot_beat_t                fold_d, fold_q;

  assign xr   = (mx_q + XY_RND) >>> SCALE_SH;
  assign yr   = (my_q + XY_RND) >>> SCALE_SH;
  assign x0   = xr[WORK_W-1:0];
  assign y0   = yr[WORK_W-1:0];
  assign ar   = ap_q + ANG_RND;
  assign turn = ar[APROD_W-1 -: TURN_W];
  assign zw   = {{(ANG_W-TURN_W){turn[TURN_W-1]}}, turn};

  always_comb begin
    fold_d.pivot_x = pvx2_q;
    fold_d.pivot_y = pvy2_q;
    unique if (zw > ANG_QUARTER) begin
      fold_d.x = -x0;
      fold_d.y = -y0;
      fold_d.z = zw - ANG_HALF;
    end else if (zw < ANG_NEG_QUARTER) begin
      fold_d.x = -x0;
      fold_d.y = -y0;
      fold_d.z = zw + ANG_HALF;
    end else begin
      fold_d.x = x0;
      fold_d.y = y0;
      fold_d.z = zw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) fold_q <= fold_d;
  end

  assign beat_o = fold_q;

endmodule

`default_nettype wire

>>> hw/rtl/prap_cordic_stage.sv
// prap_cordic_stage: one registered CORDIC micro-rotation with shift SHIFT.
// Depends on prap_pkg.
`default_nettype none

module prap_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  prap_pkg::rot_beat_t  beat_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output prap_pkg::rot_beat_t  beat_o
);
  import prap_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP = ANG_W'(atan_turn(5'(SHIFT)));

  logic                     valid_q;
  rot_beat_t                beat_d, beat_q;
  logic signed [WORK_W-1:0] sx, sy;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  assign sx = $signed(beat_i.x) >>> SHIFT;
  assign sy = $signed(beat_i.y) >>> SHIFT;

  always_comb begin
    beat_d = beat_i;
    if (!beat_i.z[ANG_W-1]) begin
      beat_d.x = beat_i.x - sy;
      beat_d.y = beat_i.y + sx;
      beat_d.z = beat_i.z - STEP;
    end else begin
      beat_d.x = beat_i.x + sy;
      beat_d.y = beat_i.y - sx;
      beat_d.z = beat_i.z + STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) beat_q <= beat_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/prap_finish.sv
// prap_finish: drops guard bits, adds the pivot back, saturates; output register.
// Depends on prap_pkg.
`default_nettype none

module prap_finish (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  prap_pkg::rot_beat_t  beat_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output prap_pkg::out_beat_t  beat_o
);
  import prap_pkg::*;

  localparam logic signed [WORK_W-1:0] G_RND = WORK_W'(64'd1 << (GUARD_BITS - 1));

  // {saturated, value}
  function automatic logic [COORD_W:0] round_sat(input logic signed [WORK_W-1:0]  v,
                                                 input logic signed [COORD_W-1:0] piv);
    logic signed [WORK_W-1:0] rv;
    logic signed [WORK_W:0]   r;
    logic [WORK_W:COORD_W-1]  hi;
    logic [COORD_W:0]         res;
    rv = (v + G_RND) >>> GUARD_BITS;
    r  = (WORK_W+1)'(rv) + (WORK_W+1)'(piv);
    hi = r[WORK_W:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      res = {1'b0, r[COORD_W-1:0]};
    end else if (r[WORK_W]) begin
      res = {1'b1, COORD_MIN};
    end else begin
      res = {1'b1, COORD_MAX};
    end
    return res;
  endfunction

  logic             valid_q;
  out_beat_t        beat_q, beat_d;
  logic [COORD_W:0] rx, ry;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  assign rx = round_sat(beat_i.x, beat_i.pivot_x);
  assign ry = round_sat(beat_i.y, beat_i.pivot_y);

  always_comb begin
    beat_d.rotated_x = rx[COORD_W-1:0];
    beat_d.rotated_y = ry[COORD_W-1:0];
    beat_d.overflow  = rx[COORD_W] | ry[COORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) beat_q <= beat_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/point_rotate_about_pivot_unit.sv
// point_rotate_about_pivot_unit: rotates a Q16.16 point about a pivot with a CORDIC pipeline.
// Depends on prap_pkg, prap_stream_if, prap_prep, prap_cordic_stage, prap_finish.
//
//   channel  dir  beat type            contents
//   in_i     in   prap_pkg::in_beat_t  point, pivot, angle, degree select
//   out_o    out  prap_pkg::out_beat_t rotated point, overflow flag
//
// One beat per cycle sustained while the output accepts beats. The pipeline has three
// front-end stages (offset, multiplies, fold), one per micro-rotation, one output stage.
// Depth is set by the micro-rotation count; each stage holds one register slice.
// Reset clears only the stage valid bits; the datapath carries no state between beats.
// Every stage loads when it is empty or its successor loads, so bubbles close up and a
// stalled output holds the pipe without dropping or repeating a beat.
`default_nettype none

module point_rotate_about_pivot_unit #(
  parameter int unsigned CORDIC_STAGES = 24   // 12 .. 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  prap_stream_if.sink   in_i,
  prap_stream_if.source out_o
);
  import prap_pkg::*;

  // c_*[k] is the handoff into micro-rotation k; index CORDIC_STAGES feeds the output stage
  logic [CORDIC_STAGES:0] c_valid;
  logic [CORDIC_STAGES:0] c_ready;
  rot_beat_t              c_beat [CORDIC_STAGES+1];

  // Front end: offset, gain pre-scale, binary angle, fold into +/- a quarter turn
  prap_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .beat_i  (in_i.data),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .beat_o  (c_beat[0])
  );

  // Unrolled micro-rotations, shift k at stage k
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    prap_cordic_stage #(
      .SHIFT (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[g]),
      .ready_o (c_ready[g]),
      .beat_i  (c_beat[g]),
      .valid_o (c_valid[g+1]),
      .ready_i (c_ready[g+1]),
      .beat_o  (c_beat[g+1])
    );
  end

  // Guard-bit rounding, pivot add-back, saturation, output register
  prap_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid[CORDIC_STAGES]),
    .ready_o (c_ready[CORDIC_STAGES]),
    .beat_i  (c_beat[CORDIC_STAGES]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .beat_o  (out_o.data)
  );

  // An empty output register means every stage can load, so input must be open
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input blocked while output stage empty");

  // Residual angle after the fold stays within a quarter turn
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[0] |-> (c_beat[0].z <= ANG_QUARTER) && (c_beat[0].z >= ANG_NEG_QUARTER))
    else $error("folded angle out of range");

  // Overflow flag only with a coordinate pinned at a bound
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.overflow |->
      (out_o.data.rotated_x == COORD_MAX) || (out_o.data.rotated_x == COORD_MIN) ||
      (out_o.data.rotated_y == COORD_MAX) || (out_o.data.rotated_y == COORD_MIN))
    else $error("overflow flagged without saturated coordinate");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking bench for point_rotate_about_pivot_unit.
// Drives point/pivot/angle beats, predicts each rotated point and checks it.
// Depends on prap_pkg, prap_stream_if and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
  import prap_pkg::*;

  // Pipeline shape, from the unit's header: front end 3, one per micro-rotation, output 1.
  localparam int unsigned STAGES      = 24;
  localparam int unsigned LATENCY     = 3 + STAGES + 1;
  localparam int unsigned ITEMS       = 1700;
  localparam int unsigned QUIET_TAIL  = 150;     // last beats run with no idling
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Q16.16 handy values
  localparam logic [COORD_W-1:0] ONE     = 32'h0001_0000;
  localparam logic [COORD_W-1:0] DEG45   = 32'h002D_0000;
  localparam logic [COORD_W-1:0] DEG90   = 32'h005A_0000;
  localparam logic [COORD_W-1:0] DEG135  = 32'h0087_0000;
  localparam logic [COORD_W-1:0] DEG180  = 32'h00B4_0000;
  localparam logic [COORD_W-1:0] DEG360  = 32'h0168_0000;
  localparam logic [COORD_W-1:0] DEG720  = 32'h02D0_0000;
  localparam logic [COORD_W-1:0] RAD_PI  = 32'd205887;   // pi in Q16.16
  localparam logic [COORD_W-1:0] RAD_PI2 = 32'd102944;   // pi/2 in Q16.16
  localparam longint              DEG_SPAN = 360 * 65536; // one turn in degree units
  localparam longint              RAD_SPAN = 411775;      // one turn in radian units

  // Arctangent of 2^-i as a fraction of a full turn (2^32 = one turn)
  localparam longint ARC_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // One row of the directed plan; 'typed' rows carry a hand-written expectation
  typedef struct {
    in_beat_t  stim;
    bit        typed;
    out_beat_t want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  prap_stream_if #(.beat_t(in_beat_t))  in_ch ();
  prap_stream_if #(.beat_t(out_beat_t)) out_ch ();

  point_rotate_about_pivot_unit #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  out_beat_t   due_rotations[$];   // predicted beats, oldest first
  out_beat_t   landed_want;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  bit          calm        = 1'b0; // no idling on either side while set

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Drop the guard bits with round-half-up, add the pivot back, clamp to Q16.16.
  function automatic logic [COORD_W-1:0] settle_coord(longint v, longint piv,
                                                      inout logic sat);
    longint r;
    r = ((v + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS) + piv;
    if (r > longint'(COORD_MAX)) begin
      r   = longint'(COORD_MAX);
      sat = 1'b1;
    end else if (r < longint'(COORD_MIN)) begin
      r   = longint'(COORD_MIN);
      sat = 1'b1;
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic out_beat_t rotate_about_pivot(in_beat_t b);
    longint      pvx, pvy, x, y, z, sx, sy;
    logic [63:0] aprod;
    logic [31:0] turn;
    logic        sat;
    out_beat_t   r;
    pvx = longint'($signed(b.pivot_x));
    pvy = longint'($signed(b.pivot_y));
    // Offset is exact; prescale by the CORDIC gain into Q16.16 + guard bits
    x = ((longint'($signed(b.point_x)) - pvx) * longint'(GAIN_Q30)
         + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
    y = ((longint'($signed(b.point_y)) - pvy) * longint'(GAIN_Q30)
         + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
    // Angle to binary turns; everything above one turn wraps away
    aprod = longint'($signed(b.turn_angle))
            * longint'(b.angle_in_degrees ? DEG_TO_TURN : RAD_TO_TURN)
            + longint'(32768);
    turn = aprod[47:16];
    z    = longint'($signed(turn));
    // Fold beyond a quarter turn: negate the vector, move z by half a turn
    if (z > (longint'(1) << 30)) begin
      x = -x;
      y = -y;
      z = z - (longint'(1) << 31);
    end else if (z < -(longint'(1) << 30)) begin
      x = -x;
      y = -y;
      z = z + (longint'(1) << 31);
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (z >= 0) begin
        x = x - sy;
        y = y + sx;
        z = z - ARC_STEP[i];
      end else begin
        x = x + sy;
        y = y - sx;
        z = z + ARC_STEP[i];
      end
    end
    sat         = 1'b0;
    r.rotated_x = settle_coord(x, pvx, sat);
    r.rotated_y = settle_coord(y, pvy, sat);
    r.overflow  = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t plan_row(logic [31:0] ptx, logic [31:0] pty,
                                         logic [31:0] pvx, logic [31:0] pvy,
                                         logic [31:0] ang, bit deg, bit typed = 1'b0,
                                         logic [31:0] wx = '0, logic [31:0] wy = '0,
                                         bit wo = 1'b0);
    plan_row_t r;
    r.stim.point_x          = ptx;
    r.stim.point_y          = pty;
    r.stim.pivot_x          = pvx;
    r.stim.pivot_y          = pvy;
    r.stim.turn_angle       = ang;
    r.stim.angle_in_degrees = deg;
    r.typed                 = typed;
    r.want.rotated_x        = wx;
    r.want.rotated_y        = wy;
    r.want.overflow         = wo;
    return r;
  endfunction

  // Mostly small coordinates, some mid-range, some anywhere, some at the rails
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(1048575)) - 32'd524288;   // within +-8.0
      4, 5:       return 32'($urandom_range(32'h0FFF_FFFF)) - 32'h0800_0000;
      6, 7:       return $urandom();
      8: begin
        case ($urandom_range(3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
      default:    return 32'($urandom_range(65535));                  // below 1.0
    endcase
  endfunction

  function automatic logic [31:0] rand_angle(bit deg);
    longint span;
    int     quad;
    span = deg ? DEG_SPAN : RAD_SPAN;
    case ($urandom_range(5))
      0: return 32'(longint'($urandom_range(32'(2 * span))) - span);  // within one turn
      1: begin                                                        // right angles
        quad = int'($urandom_range(16)) - 8;
        return deg ? 32'(quad * 90 * 65536) : 32'(quad * 102944);
      end
      2, 3: return $urandom();                                        // far wrap
      4:    return 32'($urandom_range(131072)) - 32'd65536;           // within +-1
      default: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  function automatic in_beat_t draw_point();
    in_beat_t b;
    b.point_x          = rand_coord();
    b.point_y          = rand_coord();
    // plain rotation about the origin is the common use
    b.pivot_x          = ($urandom_range(4) < 2) ? '0 : rand_coord();
    b.pivot_y          = ($urandom_range(4) < 2) ? '0 : rand_coord();
    b.angle_in_degrees = $urandom_range(1);
    b.turn_angle       = rand_angle(b.angle_in_degrees);
    return b;
  endfunction

  // Present one beat from a falling edge, record its expectation at the accepting
  // rising edge, and return at the next falling edge. Valid stays up between beats
  // unless an idle burst is drawn.
  task automatic send_point(in_beat_t b, bit typed, out_beat_t want);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap          = $urandom_range(16, 1);
      in_ch.valid  = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    due_rotations.push_back(typed ? want : rotate_about_pivot(b));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure bursts, driven at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(4) == 0) begin
        stall_left   = $urandom_range(16, 1) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_rotations.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] unexpected beat: x %h y %h ovf %b", $realtime,
                   out_ch.data.rotated_x, out_ch.data.rotated_y, out_ch.data.overflow);
      end else begin
        landed_want = due_rotations.pop_front();
        if (out_ch.data.rotated_x !== landed_want.rotated_x ||
            out_ch.data.rotated_y !== landed_want.rotated_y ||
            out_ch.data.overflow  !== landed_want.overflow) begin
          fault_count++;
          if (fault_count <= 10)
            $display("[%0t] mismatch: x exp %h got %h, y exp %h got %h, ovf exp %b got %b",
                     $realtime, landed_want.rotated_x, out_ch.data.rotated_x,
                     landed_want.rotated_y, out_ch.data.rotated_y,
                     landed_want.overflow, out_ch.data.overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan[$];
    in_beat_t  beat;
    out_beat_t none;

    none        = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed plan. Point on the pivot stays put; huge offsets turned half a turn
    // land far outside Q16.16 and must clamp with the flag set.
    plan.push_back(plan_row('0, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0, 1'b0));
    plan.push_back(plan_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1,
                            1'b1, COORD_MAX, COORD_MAX, 1'b0));
    plan.push_back(plan_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0,
                            1'b1, COORD_MIN, COORD_MIN, 1'b0));
    plan.push_back(plan_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, DEG180, 1'b1,
                            1'b1, COORD_MAX, COORD_MAX, 1'b1));
    plan.push_back(plan_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, DEG180, 1'b1,
                            1'b1, COORD_MIN, COORD_MIN, 1'b1));
    plan.push_back(plan_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, RAD_PI, 1'b0,
                            1'b1, COORD_MIN, COORD_MIN, 1'b1));
    // Plain rotations, both quadrant folds, wraps past a full turn
    plan.push_back(plan_row(ONE, '0, '0, '0, DEG90, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, -DEG90, 1'b1));
    plan.push_back(plan_row(ONE, ONE, '0, '0, DEG45, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, DEG135, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, -DEG135, 1'b1));
    plan.push_back(plan_row('0, ONE, '0, '0, DEG180, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, DEG360, 1'b1));
    plan.push_back(plan_row(ONE, ONE, '0, '0, DEG720, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, COORD_MAX, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, COORD_MIN, 1'b1));
    plan.push_back(plan_row(ONE, '0, '0, '0, COORD_MAX, 1'b0));
    plan.push_back(plan_row(ONE, '0, '0, '0, '0, 1'b0));
    // About a real pivot, and saturation from plain rotation
    plan.push_back(plan_row(32'h000B_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                            DEG90, 1'b1));
    plan.push_back(plan_row(COORD_MAX, COORD_MAX, '0, '0, DEG45, 1'b1));
    plan.push_back(plan_row(COORD_MIN, COORD_MIN, '0, '0, -DEG45, 1'b1));
    plan.push_back(plan_row(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, RAD_PI2, 1'b0));
    plan.push_back(plan_row('0, '0, COORD_MIN, COORD_MIN, ONE, 1'b0));
    plan.push_back(plan_row(-ONE, -ONE, ONE, ONE, -RAD_PI, 1'b0));

    foreach (plan[k]) send_point(plan[k].stim, plan[k].typed, plan[k].want);

    // Random part; every fifth hundred and the tail run with no idling
    for (int k = 0; k < ITEMS; k++) begin
      calm = (k >= ITEMS - QUIET_TAIL) || ((k / 100) % 5 == 4);
      if (k == ITEMS / 2) begin
        // hold the input off until the pipe has fully drained
        in_ch.valid = 1'b0;
        while (due_rotations.size() != 0) @(negedge clk_i);
      end
      beat = draw_point();
      send_point(beat, 1'b0, none);
    end
    in_ch.valid = 1'b0;

    while (due_rotations.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
